### hw/rtl/particle_swarm_minimizer_core_defines.svh
// Assertion macros for the swarm minimizer core.
`ifndef PARTICLE_SWARM_MINIMIZER_CORE_DEFINES_SVH
`define PARTICLE_SWARM_MINIMIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PSM_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);
`else
`define PSM_ASSERT(lbl, prop, msg)
`define PSM_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif
`endif

### hw/rtl/psm_pkg.sv
`timescale 1ns / 1ps
package psm_pkg;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned VAL_W   = 64;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned SIZE_W  = 11;
	localparam int unsigned CIDX_W  = 1;
	localparam int unsigned MOP_W   = 40;
	localparam int unsigned MHALF_W = 20;
	localparam int unsigned MPROD_W = 80;

	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ITER  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_LOWER = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_UPPER = 1'b1;

	localparam logic signed [POS_W-1:0] LOWER_RST = -32'sd100663296;
	localparam logic signed [POS_W-1:0] UPPER_RST = 32'sd100663296;
	localparam logic signed [VAL_W-1:0] OBJ_CONST = 64'sd33554432;

	typedef struct packed {
		logic signed [VAL_W-1:0] pval;
		logic signed [POS_W-1:0] pbest;
		logic signed [POS_W-1:0] vel;
		logic signed [POS_W-1:0] pos;
	} psm_entry_t;

	typedef struct packed {
		logic             start;
		logic [MOP_W-1:0] a;
		logic [MOP_W-1:0] b;
	} psm_mul_req_t;

	typedef struct packed {
		logic               done;
		logic [MPROD_W-1:0] p;
	} psm_mul_rsp_t;

	// floor(+-m / 2^16) for a magnitude below 2^48
	function automatic logic signed [33:0] floor_shr16(input logic neg,
		input logic [MPROD_W-1:0] m);
		logic [MPROD_W-1:0] t;
		logic signed [33:0] q;
		t = m - MPROD_W'(1);
		if (!neg || m == '0) begin
			return $signed({2'b00, m[47:16]});
		end
		q = $signed({2'b00, t[47:16]});
		return -q - 34'sd1;
	endfunction
endpackage

### hw/rtl/psm_if.sv
`timescale 1ns / 1ps
interface psm_in_if;
	logic                          valid;
	logic                          ready;
	logic [psm_pkg::MODE_W-1:0]    mode;
	logic [psm_pkg::FRAC_W-1:0]    init_fraction;
	logic [psm_pkg::FRAC_W-1:0]    coef_local;
	logic [psm_pkg::FRAC_W-1:0]    coef_global;
	modport source (output valid, mode, init_fraction, coef_local, coef_global, input ready);
	modport sink (input valid, mode, init_fraction, coef_local, coef_global, output ready);
endinterface

interface psm_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [psm_pkg::POS_W-1:0]  best_position;
	logic signed [psm_pkg::VAL_W-1:0]  best_value;
	logic [psm_pkg::SIZE_W-1:0]        swarm_size;
	modport source (output valid, best_position, best_value, swarm_size, input ready);
	modport sink (input valid, best_position, best_value, swarm_size, output ready);
endinterface

interface psm_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [psm_pkg::CIDX_W-1:0]   index;
	logic [psm_pkg::POS_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/psm_ram.sv
`timescale 1ns / 1ps
module psm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/psm_mul.sv
`timescale 1ns / 1ps
module psm_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  psm_pkg::psm_mul_req_t req,
	output psm_pkg::psm_mul_rsp_t rsp
);
	localparam int unsigned HP_W = psm_pkg::MOP_W + psm_pkg::MHALF_W;

	logic [psm_pkg::MOP_W-1:0]   a_q;
	logic [psm_pkg::MOP_W-1:0]   b_q;
	logic [HP_W-1:0]             lo_q;
	logic                        ph1_q;
	logic                        ph2_q;
	logic [psm_pkg::MHALF_W-1:0] b_half;
	logic [HP_W-1:0]             prod;

	assign b_half = ph1_q ? b_q[psm_pkg::MHALF_W-1:0] : b_q[psm_pkg::MOP_W-1:psm_pkg::MHALF_W];
	assign prod   = HP_W'(a_q) * HP_W'(b_half);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q      <= '0;
			b_q      <= '0;
			lo_q     <= '0;
			ph1_q    <= 1'b0;
			ph2_q    <= 1'b0;
			rsp.done <= 1'b0;
			rsp.p    <= '0;
		end else begin
			rsp.done <= 1'b0;
			ph1_q    <= req.start;
			ph2_q    <= ph1_q;
			if (req.start) begin
				a_q <= req.a;
				b_q <= req.b;
			end
			if (ph1_q) begin
				lo_q <= prod;
			end
			if (ph2_q) begin
				rsp.p    <= psm_pkg::MPROD_W'(lo_q) + {prod, {psm_pkg::MHALF_W{1'b0}}};
				rsp.done <= 1'b1;
			end
		end
	end
endmodule

### hw/rtl/particle_swarm_minimizer_core.sv
`timescale 1ns / 1ps
// Channel  Modport  Carries
// in_ch    sink     mode, init_fraction, coef_local, coef_global
// out_ch   source   best_position, best_value, swarm_size
// cfg_ch   sink     index (0 lower_bound, 1 upper_bound), data
//
// An iterate is paced by the one shared 40x20 multiplier, which runs two passes per
// product for five products per particle, and by the particle RAM port.
// in_ch is ready only between items; the result sits in an output register, so
// the next item is taken while it waits. No clearing pass: the RAM is read only
// below the particle count. Config writes are always taken, one per cycle.
`include "particle_swarm_minimizer_core_defines.svh"
module particle_swarm_minimizer_core #(
	parameter int unsigned MAX_PARTICLES = 1024
) (
	input logic    clk,
	input logic    arst_n,
	psm_in_if.sink    in_ch,
	psm_out_if.source out_ch,
	psm_cfg_if.sink   cfg_ch
);
	localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);
	localparam int unsigned AW = MAX_PARTICLES > 1 ? $clog2(MAX_PARTICLES) : 1;
	localparam int unsigned EW = $bits(psm_pkg::psm_entry_t);

	typedef enum logic [4:0] {
		ST_IDLE, ST_LD_MUL, ST_LD_WAIT, ST_IT_RD, ST_IT_LAT, ST_IT_VL, ST_IT_VLW,
		ST_IT_VG, ST_IT_VGW, ST_IT_MOVE, ST_OB_X2, ST_OB_X2W, ST_OB_X3, ST_OB_X3W,
		ST_OB_X4, ST_OB_X4W, ST_OB_S1, ST_OB_S2, ST_LD_FIN, ST_IT_FIN, ST_IT_END,
		ST_RESULT
	} state_t;

	state_t                          state_q;
	logic                            is_load_q;
	logic signed [31:0]              lower_q;
	logic signed [31:0]              upper_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   idx_q;
	logic signed [31:0]              gb_pos_q;
	logic signed [63:0]              gb_val_q;
	logic                            gb_valid_q;
	logic signed [31:0]              rb_pos_q;
	logic signed [63:0]              rb_val_q;
	logic [15:0]                     frac_q;
	logic [15:0]                     wl_q;
	logic [15:0]                     wg_q;
	psm_pkg::psm_entry_t             ent_q;
	logic signed [33:0]              t1_q;
	logic signed [31:0]              vnew_q;
	logic signed [31:0]              x_q;
	logic [38:0]                     x2_q;
	logic signed [63:0]              x3_q;
	logic signed [63:0]              f_q;
	logic                            out_valid_q;
	logic signed [31:0]              out_pos_q;
	logic signed [63:0]              out_val_q;
	logic [psm_pkg::SIZE_W-1:0]      out_size_q;
	psm_pkg::psm_mul_req_t           mreq_q;
	psm_pkg::psm_mul_rsp_t           mrsp;

	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	psm_pkg::psm_entry_t             ram_wentry;
	logic [EW-1:0]                   ram_rdata;
	psm_pkg::psm_entry_t             ram_rentry;

	logic signed [32:0]              diff;
	logic [32:0]                     diff_mag;
	logic signed [32:0]              dl;
	logic [32:0]                     dl_mag;
	logic signed [32:0]              dg;
	logic [32:0]                     dg_mag;
	logic [31:0]                     mx;
	logic signed [33:0]              fsh;
	logic signed [35:0]              vsum;
	logic signed [32:0]              xsum;
	logic signed [33:0]              ld_sum;
	logic [45:0]                     x3m;
	logic signed [63:0]              x2s;
	logic signed [63:0]              f_fin;
	logic                            pb_better;
	logic signed [63:0]              pv_new;
	logic signed [31:0]              pb_new;

	assign diff     = {upper_q[31], upper_q} - {lower_q[31], lower_q};
	assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
	assign dl       = {ent_q.pbest[31], ent_q.pbest} - {ent_q.pos[31], ent_q.pos};
	assign dl_mag   = dl[32] ? 33'(-dl) : 33'(dl);
	assign dg       = {gb_pos_q[31], gb_pos_q} - {ent_q.pos[31], ent_q.pos};
	assign dg_mag   = dg[32] ? 33'(-dg) : 33'(dg);
	assign mx       = x_q[31] ? (~x_q + 32'd1) : x_q;
	assign fsh      = psm_pkg::floor_shr16(state_q == ST_LD_WAIT ? diff[32]
		: (state_q == ST_IT_VLW ? dl[32] : dg[32]), mrsp.p);
	assign vsum     = 36'(ent_q.vel) + 36'(t1_q) + 36'(fsh);
	assign xsum     = 33'(ent_q.pos) + 33'(vnew_q);
	assign ld_sum   = 34'(lower_q) + fsh;
	assign x3m      = mrsp.p[69:24];
	assign x2s      = $signed({25'd0, x2_q});
	assign f_fin    = f_q - (x2s <<< 3) - (x2s <<< 1) + (64'(x_q) <<< 2) + psm_pkg::OBJ_CONST;
	assign pb_better = f_q < ent_q.pval;
	assign pv_new   = pb_better ? f_q : ent_q.pval;
	assign pb_new   = pb_better ? x_q : ent_q.pbest;

	assign ram_rentry = psm_pkg::psm_entry_t'(ram_rdata);
	assign ram_we     = (state_q == ST_LD_FIN) || (state_q == ST_IT_FIN);
	assign ram_waddr  = (state_q == ST_LD_FIN) ? count_q[AW-1:0] : idx_q[AW-1:0];
	always_comb begin
		if (state_q == ST_LD_FIN) begin
			ram_wentry.pval  = f_q;
			ram_wentry.pbest = x_q;
			ram_wentry.vel   = '0;
			ram_wentry.pos   = x_q;
		end else begin
			ram_wentry.pval  = pv_new;
			ram_wentry.pbest = pb_new;
			ram_wentry.vel   = vnew_q;
			ram_wentry.pos   = x_q;
		end
	end

	psm_ram #(.WIDTH(EW), .DEPTH(MAX_PARTICLES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (EW'(ram_wentry)),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	psm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq_q),
		.rsp    (mrsp)
	);

	assign in_ch.ready          = (state_q == ST_IDLE);
	assign cfg_ch.ready         = 1'b1;
	assign out_ch.valid         = out_valid_q;
	assign out_ch.best_position = out_pos_q;
	assign out_ch.best_value    = out_val_q;
	assign out_ch.swarm_size    = out_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			is_load_q   <= 1'b0;
			lower_q     <= psm_pkg::LOWER_RST;
			upper_q     <= psm_pkg::UPPER_RST;
			count_q     <= '0;
			idx_q       <= '0;
			gb_pos_q    <= '0;
			gb_val_q    <= '0;
			gb_valid_q  <= 1'b0;
			rb_pos_q    <= '0;
			rb_val_q    <= '0;
			frac_q      <= '0;
			wl_q        <= '0;
			wg_q        <= '0;
			ent_q       <= '0;
			t1_q        <= '0;
			vnew_q      <= '0;
			x_q         <= '0;
			x2_q        <= '0;
			x3_q        <= '0;
			f_q         <= '0;
			out_valid_q <= 1'b0;
			out_pos_q   <= '0;
			out_val_q   <= '0;
			out_size_q  <= '0;
			mreq_q      <= '0;
		end else begin
			mreq_q.start <= (state_q == ST_LD_MUL) || (state_q == ST_IT_VL)
				|| (state_q == ST_IT_VG) || (state_q == ST_OB_X2)
				|| (state_q == ST_OB_X3) || (state_q == ST_OB_X4);
			if (out_valid_q && out_ch.ready && state_q != ST_RESULT) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_ch.valid) begin
				case (cfg_ch.index)
					psm_pkg::CFG_LOWER: lower_q <= $signed(cfg_ch.data);
					psm_pkg::CFG_UPPER: upper_q <= $signed(cfg_ch.data);
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						frac_q <= in_ch.init_fraction;
						wl_q   <= in_ch.coef_local;
						wg_q   <= in_ch.coef_global;
						idx_q  <= '0;
						case (in_ch.mode)
							psm_pkg::MODE_LOAD: begin
								is_load_q <= 1'b1;
								state_q   <= (count_q >= CW'(MAX_PARTICLES)) ? ST_RESULT : ST_LD_MUL;
							end
							psm_pkg::MODE_ITER: begin
								is_load_q <= 1'b0;
								state_q   <= (count_q == '0) ? ST_RESULT : ST_IT_RD;
							end
							psm_pkg::MODE_CLEAR: begin
								count_q    <= '0;
								gb_pos_q   <= '0;
								gb_val_q   <= '0;
								gb_valid_q <= 1'b0;
								state_q    <= ST_RESULT;
							end
							default: ;
						endcase
					end
				end
				ST_LD_MUL: begin
					mreq_q.a     <= 40'(diff_mag);
					mreq_q.b     <= 40'(frac_q);
					state_q      <= ST_LD_WAIT;
				end
				ST_LD_WAIT: begin
					if (mrsp.done) begin
						x_q     <= ld_sum[31:0];
						state_q <= ST_OB_X2;
					end
				end
				ST_IT_RD: state_q <= ST_IT_LAT;
				ST_IT_LAT: begin
					ent_q   <= ram_rentry;
					state_q <= ST_IT_VL;
				end
				ST_IT_VL: begin
					mreq_q.a     <= 40'(dl_mag);
					mreq_q.b     <= 40'(wl_q);
					state_q      <= ST_IT_VLW;
				end
				ST_IT_VLW: begin
					if (mrsp.done) begin
						t1_q    <= fsh;
						state_q <= ST_IT_VG;
					end
				end
				ST_IT_VG: begin
					mreq_q.a     <= 40'(dg_mag);
					mreq_q.b     <= 40'(wg_q);
					state_q      <= ST_IT_VGW;
				end
				ST_IT_VGW: begin
					if (mrsp.done) begin
						if (vsum > 36'sd2147483647) begin
							vnew_q <= 32'sh7fffffff;
						end else if (vsum < -36'sd2147483648) begin
							vnew_q <= 32'sh80000000;
						end else begin
							vnew_q <= vsum[31:0];
						end
						state_q <= ST_IT_MOVE;
					end
				end
				ST_IT_MOVE: begin
					if (xsum > 33'(upper_q)) begin
						x_q <= upper_q;
					end else if (xsum < 33'(lower_q)) begin
						x_q <= lower_q;
					end else begin
						x_q <= xsum[31:0];
					end
					state_q <= ST_OB_X2;
				end
				ST_OB_X2: begin
					mreq_q.a     <= 40'(mx);
					mreq_q.b     <= 40'(mx);
					state_q      <= ST_OB_X2W;
				end
				ST_OB_X2W: begin
					if (mrsp.done) begin
						x2_q    <= mrsp.p[62:24];
						state_q <= ST_OB_X3;
					end
				end
				ST_OB_X3: begin
					mreq_q.a     <= 40'(x2_q);
					mreq_q.b     <= 40'(mx);
					state_q      <= ST_OB_X3W;
				end
				ST_OB_X3W: begin
					if (mrsp.done) begin
						x3_q    <= x_q[31] ? -$signed(64'(x3m)) : $signed(64'(x3m));
						state_q <= ST_OB_X4;
					end
				end
				ST_OB_X4: begin
					mreq_q.a     <= 40'(x2_q);
					mreq_q.b     <= 40'(x2_q);
					state_q      <= ST_OB_X4W;
				end
				ST_OB_X4W: begin
					if (mrsp.done) begin
						f_q     <= $signed(64'(mrsp.p[76:24])) - x3_q;
						state_q <= ST_OB_S1;
					end
				end
				ST_OB_S1: begin
					f_q     <= f_fin;
					state_q <= ST_OB_S2;
				end
				ST_OB_S2: state_q <= is_load_q ? ST_LD_FIN : ST_IT_FIN;
				ST_LD_FIN: begin
					if (!gb_valid_q || f_q < gb_val_q) begin
						gb_valid_q <= 1'b1;
						gb_val_q   <= f_q;
						gb_pos_q   <= x_q;
					end
					count_q <= count_q + CW'(1);
					state_q <= ST_RESULT;
				end
				ST_IT_FIN: begin
					if (idx_q == '0 || pv_new < rb_val_q) begin
						rb_val_q <= pv_new;
						rb_pos_q <= pb_new;
					end
					idx_q   <= idx_q + CW'(1);
					state_q <= (idx_q + CW'(1) < count_q) ? ST_IT_RD : ST_IT_END;
				end
				ST_IT_END: begin
					if (!gb_valid_q || rb_val_q < gb_val_q) begin
						gb_valid_q <= 1'b1;
						gb_val_q   <= rb_val_q;
						gb_pos_q   <= rb_pos_q;
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_pos_q   <= gb_pos_q;
						out_val_q   <= gb_val_q;
						out_size_q  <= psm_pkg::SIZE_W'(count_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PSM_ASSERT(a_count_bound, count_q <= CW'(MAX_PARTICLES), "particle count beyond capacity")
	`PSM_ASSERT(a_mul_latency, mreq_q.start |-> ##3 mrsp.done, "multiplier result late")
	`PSM_ASSERT(a_out_source, $rose(out_valid_q) |-> $past(state_q == ST_RESULT), "stray result")
	`PSM_ASSERT_NEXT(a_load_count, state_q == ST_LD_FIN, count_q == $past(count_q) + CW'(1), "load count")
endmodule

### bench/particle_swarm_minimizer_core_tb.sv
`timescale 1ns / 1ps
module particle_swarm_minimizer_core_tb;
	localparam logic [psm_pkg::MODE_W-1:0] MODE_NONE = 2'd3;
	localparam int unsigned NPART = 1024;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned HOLD_LEN = 500;
	localparam int unsigned SETTLE = 64;
	localparam longint INT64_MAX = 64'sh7fffffffffffffff;

	typedef struct packed {
		logic signed [psm_pkg::POS_W-1:0] pos;
		logic signed [psm_pkg::VAL_W-1:0] val;
		logic [psm_pkg::SIZE_W-1:0]       size;
	} swarm_result_t;

	typedef struct packed {
		logic [psm_pkg::MODE_W-1:0] mode;
		logic [psm_pkg::FRAC_W-1:0] frac;
		logic [psm_pkg::FRAC_W-1:0] cl;
		logic [psm_pkg::FRAC_W-1:0] cg;
		logic                       fixed;
		swarm_result_t              res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	psm_in_if  in_ch();
	psm_out_if out_ch();
	psm_cfg_if cfg_ch();

	particle_swarm_minimizer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	// swarm predictor state
	longint lo_bound, hi_bound;
	int     part_pos [NPART];
	int     part_vel [NPART];
	int     pbest_pos [NPART];
	longint pbest_val [NPART];
	int     part_count;
	int     gbest_pos;
	longint gbest_val;
	bit     gbest_valid;

	swarm_result_t expected_results [$];
	int     fails;
	int     cycles;
	int     snd_pct, rcv_pct;
	int     hold_req, hold_seen, hold_cnt;
	bit     in_held;
	int     n_items, n_results, n_iters, n_loads;
	stim_row_t directed_rows [16];

	initial begin
		clk = 1'b0;
		forever begin
			#1 clk = 1'b1;
			#1 clk = 1'b0;
		end
	end

	function automatic longint mul_q24(longint a, longint b);
		logic neg;
		logic [63:0] ma, mb, r;
		logic [127:0] p;
		neg = (a < 0) != (b < 0);
		ma = a[63] ? 64'(-a) : 64'(a);
		mb = b[63] ? 64'(-b) : 64'(b);
		p = {64'd0, ma} * {64'd0, mb};
		if (p[127:88] != 0)
			r = '1;
		else
			r = p[87:24];
		if (r > 64'(INT64_MAX))
			r = 64'(INT64_MAX);
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint quartic(int xv);
		longint x, x2, x3, x4;
		x = xv;
		x2 = mul_q24(x, x);
		x3 = mul_q24(x2, x);
		x4 = mul_q24(x2, x2);
		return x4 - x3 - 10 * x2 + 4 * x + longint'(psm_pkg::OBJ_CONST);
	endfunction

	function automatic int sat_pos(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return int'(v);
	endfunction

	task automatic load_particle(logic [psm_pkg::FRAC_W-1:0] frac);
		longint diff, p, val;
		if (part_count >= NPART)
			return;
		diff = hi_bound - lo_bound;
		p = lo_bound + ((longint'({48'd0, frac}) * diff) >>> 16);
		part_pos[part_count] = int'(p);
		part_vel[part_count] = 0;
		pbest_pos[part_count] = int'(p);
		val = quartic(int'(p));
		pbest_val[part_count] = val;
		if (!gbest_valid || val < gbest_val) begin
			gbest_valid = 1'b1;
			gbest_val = val;
			gbest_pos = int'(p);
		end
		part_count++;
	endtask

	task automatic iterate_swarm(logic [psm_pkg::FRAC_W-1:0] cl,
		logic [psm_pkg::FRAC_W-1:0] cg);
		longint wl, wg, g, x, v, val;
		int best;
		wl = longint'({48'd0, cl});
		wg = longint'({48'd0, cg});
		g = gbest_pos;
		best = 0;
		if (part_count == 0)
			return;
		for (int i = 0; i < part_count; i++) begin
			x = part_pos[i];
			v = part_vel[i];
			v += (wl * (longint'(pbest_pos[i]) - x)) >>> 16;
			v += (wg * (g - x)) >>> 16;
			part_vel[i] = sat_pos(v);
			x += part_vel[i];
			if (x > hi_bound)
				x = hi_bound;
			else if (x < lo_bound)
				x = lo_bound;
			part_pos[i] = int'(x);
			val = quartic(int'(x));
			if (val < pbest_val[i]) begin
				pbest_val[i] = val;
				pbest_pos[i] = int'(x);
			end
		end
		for (int i = 1; i < part_count; i++)
			if (pbest_val[i] < pbest_val[best])
				best = i;
		if (!gbest_valid || pbest_val[best] < gbest_val) begin
			gbest_valid = 1'b1;
			gbest_val = pbest_val[best];
			gbest_pos = pbest_pos[best];
		end
	endtask

	task automatic predict_swarm(input logic [psm_pkg::MODE_W-1:0] mode,
		input logic [psm_pkg::FRAC_W-1:0] frac,
		input logic [psm_pkg::FRAC_W-1:0] cl, input logic [psm_pkg::FRAC_W-1:0] cg,
		output bit has_res, output swarm_result_t res);
		has_res = 1'b1;
		case (mode)
			psm_pkg::MODE_LOAD: begin
				load_particle(frac);
				n_loads++;
			end
			psm_pkg::MODE_ITER: begin
				iterate_swarm(cl, cg);
				n_iters++;
			end
			psm_pkg::MODE_CLEAR: begin
				part_count = 0;
				gbest_pos = 0;
				gbest_val = 0;
				gbest_valid = 1'b0;
			end
			default: has_res = 1'b0;
		endcase
		res.pos = gbest_pos;
		res.val = gbest_val;
		res.size = psm_pkg::SIZE_W'(part_count);
	endtask

	// called at a rising edge; returns at the edge that accepts the item
	task automatic send_item(logic [psm_pkg::MODE_W-1:0] mode,
		logic [psm_pkg::FRAC_W-1:0] frac, logic [psm_pkg::FRAC_W-1:0] cl,
		logic [psm_pkg::FRAC_W-1:0] cg, bit fixed, swarm_result_t fixed_res);
		int gap;
		bit has_res;
		swarm_result_t res;
		gap = 0;
		while ($urandom_range(99) < snd_pct)
			gap++;
		if (gap > 0) begin
			if (in_held)
				in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.init_fraction <= frac;
		in_ch.coef_local <= cl;
		in_ch.coef_global <= cg;
		in_held = 1'b1;
		do @(negedge clk); while (!in_ch.ready);
		@(posedge clk);
		n_items++;
		predict_swarm(mode, frac, cl, cg, has_res, res);
		if (has_res)
			expected_results.push_back(fixed ? fixed_res : res);
	endtask

	task automatic drain;
		if (in_held)
			in_ch.valid <= 1'b0;
		in_held = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_bound(logic [psm_pkg::CIDX_W-1:0] idx,
		logic signed [psm_pkg::POS_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(negedge clk); while (!cfg_ch.ready);
		@(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == psm_pkg::CFG_LOWER)
			lo_bound = longint'(val);
		else
			hi_bound = longint'(val);
	endtask

	task automatic random_items(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (part_count >= 32 || r < 6)
				send_item(psm_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, 1'b0, '0);
			else if (r < 12)
				send_item(MODE_NONE, $urandom, $urandom, $urandom, 1'b0, '0);
			else if (r < 55)
				send_item(psm_pkg::MODE_LOAD, $urandom, $urandom, $urandom, 1'b0, '0);
			else
				send_item(psm_pkg::MODE_ITER, $urandom, $urandom, $urandom, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stall, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_cnt <= HOLD_LEN;
			out_ch.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !($urandom_range(99) < rcv_pct);
		end
	end

	always @(negedge clk) begin
		swarm_result_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected");
				fails++;
			end else begin
				e = expected_results.pop_front();
				if (out_ch.best_position !== e.pos) begin
					$error("best_position expected %0d actual %0d", e.pos, out_ch.best_position);
					fails++;
				end
				if (out_ch.best_value !== e.val) begin
					$error("best_value expected %0d actual %0d", e.val, out_ch.best_value);
					fails++;
				end
				if (out_ch.swarm_size !== e.size) begin
					$error("swarm_size expected %0d actual %0d", e.size, out_ch.swarm_size);
					fails++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.mode = psm_pkg::MODE_LOAD;
		in_ch.init_fraction = '0;
		in_ch.coef_local = '0;
		in_ch.coef_global = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = psm_pkg::CFG_LOWER;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		fails = 0;
		cycles = 0;
		snd_pct = 0;
		rcv_pct = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_cnt = 0;
		in_held = 1'b0;
		n_items = 0;
		n_results = 0;
		n_iters = 0;
		n_loads = 0;
		lo_bound = longint'(psm_pkg::LOWER_RST);
		hi_bound = longint'(psm_pkg::UPPER_RST);
		part_count = 0;
		gbest_pos = 0;
		gbest_val = 0;
		gbest_valid = 1'b0;
		directed_rows = '{
			'{psm_pkg::MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{32'sd0, 64'sd0, 11'd0}},
			'{psm_pkg::MODE_ITER,  16'h0000, 16'hffff, 16'hffff, 1'b1, '{32'sd0, 64'sd0, 11'd0}},
			'{MODE_NONE,           16'hffff, 16'hffff, 16'hffff, 1'b0, '0},
			'{psm_pkg::MODE_LOAD,  16'h0000, 16'h0000, 16'h0000, 1'b1,
				'{-32'sd100663296, 64'sd18958254080, 11'd1}},
			'{psm_pkg::MODE_LOAD,  16'hffff, 16'h0000, 16'h0000, 1'b0, '0},
			'{psm_pkg::MODE_LOAD,  16'h8000, 16'h0000, 16'h0000, 1'b0, '0},
			'{psm_pkg::MODE_LOAD,  16'h1234, 16'h0000, 16'h0000, 1'b0, '0},
			'{psm_pkg::MODE_ITER,  16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
			'{psm_pkg::MODE_ITER,  16'h0000, 16'hffff, 16'hffff, 1'b0, '0},
			'{psm_pkg::MODE_ITER,  16'h0000, 16'hffff, 16'h0000, 1'b0, '0},
			'{psm_pkg::MODE_ITER,  16'h0000, 16'h0000, 16'hffff, 1'b0, '0},
			'{psm_pkg::MODE_ITER,  16'h0000, 16'h8000, 16'h4000, 1'b0, '0},
			'{MODE_NONE,           16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
			'{psm_pkg::MODE_CLEAR, 16'hffff, 16'hffff, 16'hffff, 1'b1, '{32'sd0, 64'sd0, 11'd0}},
			'{psm_pkg::MODE_LOAD,  16'h0000, 16'hffff, 16'hffff, 1'b1,
				'{-32'sd100663296, 64'sd18958254080, 11'd1}},
			'{psm_pkg::MODE_ITER,  16'hffff, 16'h0001, 16'h0001, 1'b0, '0}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].mode, directed_rows[i].frac, directed_rows[i].cl,
				directed_rows[i].cg, directed_rows[i].fixed, directed_rows[i].res);

		for (int ph = 0; ph < 5; ph++) begin
			drain;
			case (ph)
				0: begin
					write_bound(psm_pkg::CFG_LOWER, psm_pkg::LOWER_RST);
					write_bound(psm_pkg::CFG_UPPER, psm_pkg::UPPER_RST);
				end
				1: begin
					write_bound(psm_pkg::CFG_LOWER, 32'sh80000000);
					write_bound(psm_pkg::CFG_UPPER, 32'sh7fffffff);
				end
				2: begin
					write_bound(psm_pkg::CFG_LOWER, 32'sd50331648);
					write_bound(psm_pkg::CFG_UPPER, -32'sd33554432);
				end
				3: begin
					write_bound(psm_pkg::CFG_LOWER, 32'sd16777216);
					write_bound(psm_pkg::CFG_UPPER, 32'sd16777216);
				end
				default: begin
					write_bound(psm_pkg::CFG_LOWER,
						-$signed(32'($urandom_range(32'h7fffffff))));
					write_bound(psm_pkg::CFG_UPPER, $signed(32'($urandom_range(32'h7fffffff))));
				end
			endcase
			case (ph % 4)
				0: begin snd_pct = 0; rcv_pct = 0; end
				1: begin snd_pct = 47; rcv_pct = 0; end
				2: begin snd_pct = 0; rcv_pct = 47; end
				default: begin snd_pct = 20; rcv_pct = 20; end
			endcase
			@(posedge clk);
			if (ph == 1) begin
				hold_req++;
				for (int k = 0; k < 8; k++)
					send_item(psm_pkg::MODE_LOAD, $urandom, '0, '0, 1'b0, '0);
			end
			random_items(16);
		end

		drain;
		$display("Ran %0d items: %0d loads, %0d iterates, %0d results checked",
			n_items, n_loads, n_iters, n_results);
		$display("Covered default, widest, crossed, collapsed and random bounds");
		if (fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/psm_pkg.sv
hw/rtl/psm_if.sv
hw/rtl/psm_ram.sv
hw/rtl/psm_mul.sv
hw/rtl/particle_swarm_minimizer_core.sv
bench/particle_swarm_minimizer_core_tb.sv
